// ===== design/adcsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adcsr_pkg
// Shared types and constants for the calibrated two-wire ADC serial reader.
// ----------------------------------------------------------------------------
package adcsr_pkg;

  // Serial frame: data bits first, then mode-select pulses
  localparam int DATA_BITS       = 24;
  localparam int TRAILING_PULSES = 3;
  localparam int PULSES_TOTAL    = DATA_BITS + TRAILING_PULSES;
  localparam int CNT_W           = $clog2(PULSES_TOTAL + 1);

  // Field widths
  localparam int RAW_W    = 24;
  localparam int SCALED_W = 48;
  localparam int CAL_W    = 32;
  localparam int PROD_W   = 2 * CAL_W;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  typedef enum logic {
    REG_GAIN_SLOPE  = 1'b0,
    REG_ZERO_OFFSET = 1'b1
  } reg_idx_t;

  // Sequencer: idle, clock-high half period (ST_LOW), clock-low sampling half period (ST_HIGH)
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } seq_state_t;

  typedef struct packed {
    logic read_request;
    logic data_line;
  } in_item_t;

  typedef struct packed {
    logic                       clock_line;
    logic                       reading_done;
    logic                       stale;
    logic signed [RAW_W-1:0]    raw_sample;
    logic signed [SCALED_W-1:0] scaled_value;
    logic                       ever_read;
  } out_item_t;

  // Per-tick result of the sequencer, before calibration
  typedef struct packed {
    logic                    clock_line;
    logic                    reading_done;
    logic                    stale;
    logic                    ever_read;
    logic signed [CAL_W-1:0] sample;
  } step_res_t;

endpackage

// ===== design/adcsr_seq.sv =====
// ----------------------------------------------------------------------------
// adcsr_seq
// Serial link sequencer: drives the converter clock, shifts in the sample
// and keeps the last sample. Advances one half clock period per tick.
// ----------------------------------------------------------------------------
module adcsr_seq
  import adcsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step_en,
  input  in_item_t  item,
  output step_res_t res
);

  seq_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [DATA_BITS-1:0] last_r, last_nxt;
  logic                 taken_r, taken_nxt;
  logic [DATA_BITS-1:0] shift_in;
  logic                 last_pulse;
  logic                 not_ready_req;

  // Data bit enters only during the data pulses
  assign shift_in   = (cnt_r < CNT_W'(DATA_BITS)) ?
                      {shift_r[DATA_BITS-2:0], item.data_line} : shift_r;
  assign last_pulse = (cnt_r == CNT_W'(PULSES_TOTAL - 1));
  assign not_ready_req = item.read_request && item.data_line;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    last_nxt  = last_r;
    taken_nxt = taken_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item.read_request && !item.data_line) begin
          state_nxt = ST_LOW;
          cnt_nxt   = '0;
          shift_nxt = '0;
        end
      end
      ST_LOW: begin
        state_nxt = ST_HIGH;
      end
      ST_HIGH: begin
        shift_nxt = shift_in;
        if (last_pulse) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
          last_nxt  = shift_in;
          taken_nxt = 1'b1;
        end else begin
          state_nxt = ST_LOW;
          cnt_nxt   = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Tick result
  always_comb begin
    res              = '0;
    res.ever_read    = taken_nxt;
    unique case (state_r)
      ST_IDLE: begin
        if (not_ready_req) begin
          res.reading_done = 1'b1;
          res.stale        = 1'b1;
          res.sample       = CAL_W'(signed'(last_r));
        end
      end
      ST_LOW: begin
        res.clock_line = 1'b1;
      end
      ST_HIGH: begin
        if (last_pulse) begin
          res.reading_done = 1'b1;
          res.sample       = CAL_W'(signed'(shift_in));
        end
      end
      default: begin
        res.clock_line = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      shift_r <= '0;
      last_r  <= '0;
      taken_r <= 1'b0;
    end else if (step_en) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      shift_r <= shift_nxt;
      last_r  <= last_nxt;
      taken_r <= taken_nxt;
    end
  end

endmodule

// ===== design/adcsr_cal.sv =====
// ----------------------------------------------------------------------------
// adcsr_cal
// Calibration: slope multiply, then offset add with 48-bit saturation into
// the result register.
// ----------------------------------------------------------------------------
module adcsr_cal
  import adcsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    mul_en,
  input  logic                    sat_en,
  input  step_res_t               res,
  input  logic signed [CAL_W-1:0] gain_slope,
  input  logic signed [CAL_W-1:0] zero_offset,
  output out_item_t               result
);

  step_res_t                res_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W:0]   sum;
  logic                     sat_hi, sat_lo;
  logic signed [SCALED_W-1:0] scaled;
  out_item_t                out_r, out_nxt;

  // Multiply stage
  assign prod_nxt = gain_slope * res.sample;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      res_r  <= res;
      prod_r <= prod_nxt;
    end
  end

  // Offset add and clamp to [-2^47, 2^47-1]
  assign sum    = (PROD_W+1)'(prod_r) + (PROD_W+1)'(zero_offset);
  assign sat_hi = !sum[PROD_W] && (|sum[PROD_W-1:SCALED_W-1]);
  assign sat_lo = sum[PROD_W] && !(&sum[PROD_W-1:SCALED_W-1]);

  always_comb begin
    priority if (sat_hi) begin
      scaled = {1'b0, {(SCALED_W-1){1'b1}}};
    end else if (sat_lo) begin
      scaled = {1'b1, {(SCALED_W-1){1'b0}}};
    end else begin
      scaled = sum[SCALED_W-1:0];
    end
  end

  always_comb begin
    out_nxt              = '0;
    out_nxt.clock_line   = res_r.clock_line;
    out_nxt.reading_done = res_r.reading_done;
    out_nxt.stale        = res_r.stale;
    out_nxt.ever_read    = res_r.ever_read;
    if (res_r.reading_done) begin
      out_nxt.raw_sample   = res_r.sample[RAW_W-1:0];
      out_nxt.scaled_value = scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (sat_en) begin
      out_r <= out_nxt;
    end
  end

  assign result = out_r;

endmodule

// ===== design/adc_serial_reader_calibrated.sv =====
// ----------------------------------------------------------------------------
// adc_serial_reader_calibrated
// Two-wire 24-bit ADC reader with Q16.16 slope/offset calibration.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle in and out while out_stall is low; each beat
//   is one half period of the converter clock.
// Pipeline: the input register, the sequencer plus multiplier register, and the
//   offset add and clamp register lie between input beat and result beat.
// Reset (rst_n low, synchronous): pipeline empty, sequencer idle, stored
//   sample 0, gain_slope 1.0 (65536), zero_offset 0.
module adc_serial_reader_calibrated
  import adcsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic                    v1_r, v2_r, v3_r;
  logic                    rdy1, rdy2, rdy3;
  logic                    step_en, sat_en;
  in_item_t                in_r;
  step_res_t               res;
  logic signed [CAL_W-1:0] gain_r, offset_r;
  logic                    cfg_wr;
  reg_idx_t                cfg_idx;

  // Register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= CAL_W'(65536);
      offset_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_GAIN_SLOPE:  gain_r   <= cfg_pwdata;
        REG_ZERO_OFFSET: offset_r <= cfg_pwdata;
        default:         gain_r   <= gain_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_GAIN_SLOPE:  cfg_prdata = gain_r;
      REG_ZERO_OFFSET: cfg_prdata = offset_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // Pipeline flow control: a stage moves when the next one is free
  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign step_en  = v1_r && rdy2;
  assign sat_en   = v2_r && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      in_r <= in_data;
    end
  end

  adcsr_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (in_r),
    .res     (res)
  );

  adcsr_cal u_cal (
    .clk         (clk),
    .mul_en      (step_en),
    .sat_en      (sat_en),
    .res         (res),
    .gain_slope  (gain_r),
    .zero_offset (offset_r),
    .result      (out_data)
  );

  assign out_valid = v3_r;

`ifndef SYNTHESIS
  // A fresh reading always leaves ever_read set
  a_fresh_sets_ever: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_done && !out_data.stale |-> out_data.ever_read)
    else $error("fresh reading without ever_read");

  // Stale only comes with a reading
  a_stale_is_reading: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stale |-> out_data.reading_done)
    else $error("stale flag without reading");

  // No reading: sample fields are zero
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reading_done |->
      out_data.raw_sample == '0 && out_data.scaled_value == '0)
    else $error("sample fields nonzero without reading");

  // A reading never lands on a clock-high tick
  a_clock_vs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.clock_line |-> !out_data.reading_done)
    else $error("reading delivered while clock driven high");
`endif

endmodule

// ===== dv/adc_serial_reader_calibrated_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_serial_reader_calibrated_tb
// Drives the serial reader one half-period beat at a time. Well-formed
// conversions carry random and extreme sample bits. Stale repeats, idle beats
// and broken frames are mixed in. A beat-level predictor tracks the
// sequencer and the Q16.16 calibration. Every result beat is checked field by
// field, under random sender gaps, receiver stalls and several calibration
// settings.
// ----------------------------------------------------------------------------
module adc_serial_reader_calibrated_tb;
  import adcsr_pkg::*;

  localparam int     CLK_HALF     = 5;
  localparam int     RESET_CYCLES = 8;
  localparam int     SETTLE_TICKS = 8;
  localparam int     PHASE_BEATS  = 205;
  localparam int     MAX_REPORTS  = 50;
  localparam longint SCALED_HI    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SCALED_LO    = -SCALED_HI - 1;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_data;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  adc_serial_reader_calibrated DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 100 MHz clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Predictor state: sequencer, stored sample and calibration
  logic                    seq_busy;
  logic                    seq_high;
  int                      seq_pulses;
  logic [DATA_BITS-1:0]    seq_shift;
  logic signed [RAW_W-1:0] stored_raw;
  logic                    have_sample;
  logic signed [CAL_W-1:0] cal_gain;
  logic signed [CAL_W-1:0] cal_offset;

  out_item_t expected_readings[$];

  // Traffic shaping
  int          gap_max;
  int          burst_left;
  stall_mode_t stall_mode;
  logic [7:0]  stall_mask;

  // Bookkeeping
  int mismatches;
  int beats_sent;
  int noise_beats;
  int fresh_count;
  int stale_count;
  int clamped_count;
  int setting_count;

  // Calibrated value: slope * raw + offset, clamped to 48 bits
  function automatic logic signed [SCALED_W-1:0] calibrate_sample(
    logic signed [RAW_W-1:0] raw);
    longint acc;
    acc = longint'(cal_gain) * longint'(raw) + longint'(cal_offset);
    if (acc > SCALED_HI) begin
      acc = SCALED_HI;
      clamped_count++;
    end else if (acc < SCALED_LO) begin
      acc = SCALED_LO;
      clamped_count++;
    end
    return acc[SCALED_W-1:0];
  endfunction

  // One half-period tick of the serial reader
  function automatic out_item_t predict_tick(in_item_t it);
    out_item_t res;
    res = '0;
    if (!seq_busy) begin
      if (it.read_request) begin
        if (it.data_line) begin
          // converter not ready: repeat the stored sample
          res.reading_done = 1'b1;
          res.stale        = 1'b1;
          res.raw_sample   = stored_raw;
          res.scaled_value = calibrate_sample(stored_raw);
          stale_count++;
        end else begin
          seq_busy   = 1'b1;
          seq_high   = 1'b0;
          seq_pulses = 0;
          seq_shift  = '0;
        end
      end
    end else if (!seq_high) begin
      res.clock_line = 1'b1;
      seq_high       = 1'b1;
    end else begin
      // end of a pulse: sample data seen while clock was high
      if (seq_pulses < DATA_BITS)
        seq_shift = {seq_shift[DATA_BITS-2:0], it.data_line};
      seq_pulses++;
      seq_high = 1'b0;
      if (seq_pulses >= PULSES_TOTAL) begin
        seq_busy         = 1'b0;
        seq_pulses       = 0;
        stored_raw       = seq_shift;
        have_sample      = 1'b1;
        res.reading_done = 1'b1;
        res.raw_sample   = stored_raw;
        res.scaled_value = calibrate_sample(stored_raw);
        fresh_count++;
      end
    end
    res.ever_read = have_sample;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: MISMATCH %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic check_reading(out_item_t got);
    out_item_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch("unexpected result beat", got, 0);
    end else begin
      want = expected_readings.pop_front();
      if (got.clock_line !== want.clock_line)
        report_mismatch("clock_line", got.clock_line, want.clock_line);
      if (got.reading_done !== want.reading_done)
        report_mismatch("reading_done", got.reading_done, want.reading_done);
      if (got.stale !== want.stale)
        report_mismatch("stale", got.stale, want.stale);
      if (got.raw_sample !== want.raw_sample)
        report_mismatch("raw_sample", got.raw_sample, want.raw_sample);
      if (got.scaled_value !== want.scaled_value)
        report_mismatch("scaled_value", got.scaled_value, want.scaled_value);
      if (got.ever_read !== want.ever_read)
        report_mismatch("ever_read", got.ever_read, want.ever_read);
    end
  endtask

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      check_reading(out_data);
  end

  // Receiver stall generator
  always @(negedge clk) begin
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 9) < 4);
      end
      default: begin
        out_stall  <= stall_mask[0];
        stall_mask <= {stall_mask[0], stall_mask[7:1]};
      end
    endcase
  end

  // Drop valid for n beats; payload wiggles while invalid
  task automatic pause_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= in_item_t'($urandom_range(0, 3));
    end
  endtask

  // Send one beat, in bursts with random gaps when enabled
  task automatic send_tick(logic req, logic dline);
    in_item_t it;
    it.read_request = req;
    it.data_line    = dline;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        pause_input($urandom_range(1, gap_max));
      end
      burst_left--;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_readings.push_back(predict_tick(it));
    beats_sent++;
  endtask

  // Full frame: start beat, then a clock-high and a sampling beat per pulse
  task automatic run_conversion(logic [DATA_BITS-1:0] bits, bit hold_req);
    logic dline;
    send_tick(1'b1, 1'b0);
    for (int p = 0; p < PULSES_TOTAL; p++) begin
      send_tick(hold_req ? 1'b1 : 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      dline = (p < DATA_BITS) ? bits[DATA_BITS-1-p] : 1'($urandom_range(0, 1));
      send_tick(hold_req ? 1'b1 : 1'($urandom_range(0, 1)), dline);
    end
  endtask

  // Clock out whatever frame is in flight
  task automatic finish_conversion();
    while (seq_busy) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // Wait until every expected beat is back, plus pipeline slack
  task automatic drain_results();
    pause_input(1);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic apb_access(bit is_write, reg_idx_t idx, logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_register(reg_idx_t idx, logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    apb_access(1'b0, idx, '0, got);
    if (got !== want)
      report_mismatch(idx == REG_GAIN_SLOPE ? "gain_slope read" : "zero_offset read",
                      got, want);
  endtask

  // Only called with the block idle
  task automatic set_calibration(logic [CFG_DW-1:0] gain, logic [CFG_DW-1:0] offset);
    logic [CFG_DW-1:0] unused;
    apb_access(1'b1, REG_GAIN_SLOPE, gain, unused);
    apb_access(1'b1, REG_ZERO_OFFSET, offset, unused);
    cal_gain   = gain;
    cal_offset = offset;
    setting_count++;
    check_register(REG_GAIN_SLOPE, gain);
    check_register(REG_ZERO_OFFSET, offset);
  endtask

  task automatic set_traffic(int gaps, stall_mode_t mode);
    gap_max    = gaps;
    burst_left = 0;
    stall_mask = 8'($urandom_range(1, 254));
    stall_mode = mode;
  endtask

  // Reset values, idle beats and a stale repeat before any sample exists
  task automatic test_reset_state();
    check_register(REG_GAIN_SLOPE, 32'd65536);
    check_register(REG_ZERO_OFFSET, 32'd0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    drain_results();
  endtask

  // Largest and smallest samples; requests held high while busy in the first frame
  task automatic test_extreme_samples();
    run_conversion(24'h7F_FFFF, 1'b1);
    send_tick(1'b1, 1'b1);
    run_conversion(24'h80_0000, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    drain_results();
  endtask

  // Clamping at both ends and an offset-only value, checked through stale repeats
  task automatic test_saturation();
    set_calibration(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_tick(1'b1, 1'b1);
    drain_results();
    set_calibration(32'h8000_0000, 32'h8000_0000);
    send_tick(1'b1, 1'b1);
    drain_results();
    set_calibration(32'h0000_0000, 32'h8000_0000);
    send_tick(1'b1, 1'b1);
    drain_results();
  endtask

  function automatic logic [DATA_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2:       return 24'hFF_FFFF;
      3:       return 24'h00_0000;
      default: return DATA_BITS'($urandom);
    endcase
  endfunction

  // Mostly clean frames, some stale repeats, noise and broken frames
  task automatic run_random_phase(int target);
    int start;
    int pick;
    bit held_off;
    start    = beats_sent - noise_beats;
    held_off = 1'b0;
    while (beats_sent - noise_beats - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        run_conversion(pick_sample(), 1'b0);
      end else if (pick < 82) begin
        send_tick(1'b1, 1'b1);
      end else if (pick < 92) begin
        send_tick(1'b0, 1'($urandom_range(0, 1)));
        noise_beats++;
      end else begin
        // random beat, possibly starting a frame cut short by random content
        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(0, 20))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      if (!held_off && beats_sent - noise_beats - start >= target / 2) begin
        held_off = 1'b1;
        drain_results();
      end
    end
    finish_conversion();
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [CFG_DW-1:0] gain;
    logic [CFG_DW-1:0] offset;
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin gain = 32'd65536;     offset = 32'd0;         end
        1: begin gain = 32'h7FFF_FFFF; offset = 32'h7FFF_FFFF; end
        2: begin gain = 32'h8000_0000; offset = 32'h8000_0000; end
        3: begin gain = 32'd0;         offset = $urandom;      end
        4: begin gain = $urandom;      offset = $urandom;      end
        5: begin gain = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
                  offset = $urandom; end
        default: begin gain = 32'd1;   offset = 32'd0;         end
      endcase
      set_calibration(gain, offset);
      case (ph % 4)
        0: set_traffic(0, STALL_NONE);
        1: set_traffic(3, STALL_RANDOM);
        2: set_traffic(8, STALL_PATTERN);
        default: set_traffic(2, STALL_PATTERN);
      endcase
      run_random_phase(PHASE_BEATS);
    end
    set_traffic(0, STALL_NONE);
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("adc_serial_reader_calibrated test failed");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    stall_mode  = STALL_NONE;
    stall_mask  = 8'h01;
    gap_max     = 0;
    burst_left  = 0;
    mismatches  = 0;
    beats_sent  = 0;
    noise_beats = 0;
    fresh_count = 0;
    stale_count = 0;
    clamped_count = 0;
    setting_count = 0;
    seq_busy    = 1'b0;
    seq_high    = 1'b0;
    seq_pulses  = 0;
    seq_shift   = '0;
    stored_raw  = '0;
    have_sample = 1'b0;
    cal_gain    = 32'd65536;
    cal_offset  = 32'd0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_extreme_samples();
    test_saturation();
    test_random_traffic();

    drain_results();
    $display("Sent %0d beats: %0d fresh readings, %0d stale repeats, %0d clamped values",
             beats_sent, fresh_count, stale_count, clamped_count);
    $display("Calibration settings applied: %0d, mismatches: %0d",
             setting_count, mismatches);
    if (mismatches == 0)
      $display("adc_serial_reader_calibrated test passed");
    else
      $display("adc_serial_reader_calibrated test failed");
    $finish;
  end

endmodule

// ===== adc_serial_reader_calibrated.f =====
design/adcsr_pkg.sv
design/adcsr_seq.sv
design/adcsr_cal.sv
design/adc_serial_reader_calibrated.sv
dv/adc_serial_reader_calibrated_tb.sv
